FILE: design/structure_tensor_orientation_defines.svh
// assertion macros for the structure tensor orientation block
`ifndef STRUCTURE_TENSOR_ORIENTATION_DEFINES_SVH
`define STRUCTURE_TENSOR_ORIENTATION_DEFINES_SVH

// condition holds at every edge out of reset
`define STO_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("sto assertion failed");

// antecedent implies consequent in the same cycle
`define STO_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sto implication failed");

`endif

FILE: design/sto_pkg.sv
package sto_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int ROOT_BITS    = 33;
	localparam int DIV_BITS     = 15;

	localparam int ST_SQ     = 2;
	localparam int ST_SUM    = 3;
	localparam int ST_CORD0  = 2;
	localparam int ST_ROUND  = ST_CORD0 + CORDIC_STEPS;
	localparam int ST_SQRT0  = 4;
	localparam int ST_DIV0   = ST_SQRT0 + ROOT_BITS;
	localparam int ST_DIVB0  = ST_DIV0 + 1;
	localparam int NSTAGE    = ST_DIVB0 + DIV_BITS;

	localparam logic signed [23:0] PI_Q20     = 24'sd3294199;
	localparam logic [16:0]        ORIENT_MAX = 17'd25736;
	localparam logic [15:0]        COH_ONE    = 16'd32768;

	typedef struct packed {
		logic        vld;
		logic        eof;
		logic [31:0] xx;
		logic [31:0] xy;
		logic [31:0] yy;
		logic [15:0] eps;
	} sto_in_t;

	typedef struct packed {
		logic               vld;
		logic               eof;
		logic               zero;
		logic signed [35:0] cx;
		logic signed [35:0] cy;
		logic signed [23:0] z;
		logic [32:0]        ax;
		logic [32:0]        ay;
		logic [65:0]        sq_a;
		logic [65:0]        sq_b;
		logic [66:0]        rem;
		logic [32:0]        root;
		logic [33:0]        den;
		logic [48:0]        num;
		logic               sat;
		logic [14:0]        quot;
		logic [15:0]        ori;
		logic [15:0]        coh;
	} sto_stage_t;

	function automatic logic signed [23:0] atan_q20(input int i);
		case (i)
			0:  return 24'sd823550;
			1:  return 24'sd486170;
			2:  return 24'sd256879;
			3:  return 24'sd130396;
			4:  return 24'sd65451;
			5:  return 24'sd32757;
			6:  return 24'sd16383;
			7:  return 24'sd8192;
			8:  return 24'sd4096;
			9:  return 24'sd2048;
			10: return 24'sd1024;
			11: return 24'sd512;
			12: return 24'sd256;
			13: return 24'sd128;
			14: return 24'sd64;
			15: return 24'sd32;
			16: return 24'sd16;
			17: return 24'sd8;
			18: return 24'sd4;
			19: return 24'sd2;
			default: return 24'sd0;
		endcase
	endfunction

endpackage

FILE: design/sto_datapath.sv
module sto_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  sto_pkg::sto_in_t    din,
	output sto_pkg::sto_stage_t dout
);
	import sto_pkg::*;

	sto_stage_t pipe [1:NSTAGE];
	sto_stage_t nxt  [1:NSTAGE];

	always_comb begin
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [35:0] ex;
		logic signed [35:0] ey;
		logic signed [35:0] nx;
		logic signed [35:0] ny;
		nxt[1] = '0;
		nxt[1].vld = din.vld;
		nxt[1].eof = din.eof;
		dx = $signed({1'b0, din.xx}) - $signed({1'b0, din.yy});
		dy = $signed({din.xy, 1'b0});
		ex = 36'(dx);
		ey = 36'(dy);
		nx = -ex;
		ny = -ey;
		nxt[1].zero = (dx == '0) && (dy == '0);
		nxt[1].ax = ex[35] ? nx[32:0] : ex[32:0];
		nxt[1].ay = ey[35] ? ny[32:0] : ey[32:0];
		if (dx[32]) begin
			nxt[1].cx = nx;
			nxt[1].cy = ny;
			nxt[1].z  = dy[32] ? -PI_Q20 : PI_Q20;
		end else begin
			nxt[1].cx = ex;
			nxt[1].cy = ey;
			nxt[1].z  = '0;
		end
		nxt[1].den = 34'(din.xx) + 34'(din.yy) + 34'(din.eps);
	end

	for (genvar k = 2; k <= NSTAGE; k++) begin : g_stage
		localparam int CI = k - ST_CORD0;
		localparam int SJ = ROOT_BITS - 1 - (k - ST_SQRT0);
		localparam int DI = DIV_BITS - 1 - (k - ST_DIVB0);

		always_comb begin
			logic signed [35:0] xs;
			logic signed [35:0] ys;
			logic [66:0]        trial;
			logic [22:0]        mag;
			logic [16:0]        q;
			logic [48:0]        dsh;
			logic [48:0]        n15;
			nxt[k] = pipe[k-1];
			xs = '0;
			ys = '0;
			trial = '0;
			mag = '0;
			q = '0;
			dsh = '0;
			n15 = '0;
			if (k >= ST_CORD0 && k < ST_CORD0 + CORDIC_STEPS) begin
				xs = pipe[k-1].cx >>> CI;
				ys = pipe[k-1].cy >>> CI;
				if (!pipe[k-1].cy[35]) begin
					nxt[k].cx = pipe[k-1].cx + ys;
					nxt[k].cy = pipe[k-1].cy - xs;
					nxt[k].z  = pipe[k-1].z + atan_q20(CI);
				end else begin
					nxt[k].cx = pipe[k-1].cx - ys;
					nxt[k].cy = pipe[k-1].cy + xs;
					nxt[k].z  = pipe[k-1].z - atan_q20(CI);
				end
			end
			if (k == ST_SQ) begin
				nxt[k].sq_a = 66'(pipe[k-1].ax) * 66'(pipe[k-1].ax);
				nxt[k].sq_b = 66'(pipe[k-1].ay) * 66'(pipe[k-1].ay);
			end
			if (k == ST_SUM) begin
				nxt[k].rem  = 67'(pipe[k-1].sq_a) + 67'(pipe[k-1].sq_b);
				nxt[k].root = '0;
			end
			if (k >= ST_SQRT0 && k < ST_SQRT0 + ROOT_BITS) begin
				trial = (67'(pipe[k-1].root) << (SJ + 1)) | (67'd1 << (2 * SJ));
				if (pipe[k-1].rem >= trial) begin
					nxt[k].rem  = pipe[k-1].rem - trial;
					nxt[k].root = pipe[k-1].root | (33'd1 << SJ);
				end
			end
			if (k == ST_ROUND) begin
				mag = pipe[k-1].z[23] ? 23'(-pipe[k-1].z) : pipe[k-1].z[22:0];
				q = 17'((24'(mag) + 24'd64) >> 7);
				if (q > ORIENT_MAX)
					q = ORIENT_MAX;
				if (pipe[k-1].zero)
					nxt[k].ori = '0;
				else if (pipe[k-1].z[23])
					nxt[k].ori = 16'(-q);
				else
					nxt[k].ori = q[15:0];
			end
			if (k == ST_DIV0) begin
				nxt[k].num  = (49'(pipe[k-1].root) << 15) + 49'(pipe[k-1].den >> 1);
				n15 = 49'(pipe[k-1].den) << 15;
				nxt[k].sat  = nxt[k].num >= n15;
				nxt[k].quot = '0;
			end
			if (k >= ST_DIVB0 && k < ST_DIVB0 + DIV_BITS) begin
				dsh = 49'(pipe[k-1].den) << DI;
				if (pipe[k-1].num >= dsh) begin
					nxt[k].num  = pipe[k-1].num - dsh;
					nxt[k].quot = pipe[k-1].quot | (15'd1 << DI);
				end
			end
			if (k == NSTAGE) begin
				if (pipe[k-1].den == '0)
					nxt[k].coh = (pipe[k-1].root != '0) ? COH_ONE : '0;
				else if (pipe[k-1].sat)
					nxt[k].coh = COH_ONE;
				else
					nxt[k].coh = {1'b0, nxt[k].quot};
			end
		end
	end

	for (genvar k = 1; k <= NSTAGE; k++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe[k] <= '0;
			end else if (en) begin
				pipe[k] <= nxt[k];
			end
		end
	end

	assign dout = pipe[NSTAGE];

endmodule

FILE: design/structure_tensor_orientation.sv
// structure tensor orientation and coherence, one pixel per item
// input channel s_*: tdata carries xx, xy, yy of the smoothed tensor
// (q16.16, xy signed); tlast marks the last pixel of a frame
// output channel m_*: tdata carries orientation (signed q2.14 radians)
// and coherence (unsigned q1.15, saturated at 1.0); tlast follows the input
// epsilon is written through cfg_wen / cfg_wdata; the user must write it only
// while the block is idle; the block itself has no check for this
// throughput is one item per cycle unless the receiver stalls, set by a
// 53-stage pipeline: a 20-step cordic, a squarer, a 33-step bit-serial
// square root and a 15-step restoring divider, one step per stage
// reset clears all stage valid bits and loads epsilon with 1
// when the receiver stalls the whole pipeline holds and s_tready drops,
// the last stage acting as the output register; nothing is lost or repeated
module structure_tensor_orientation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // tensor_xx, tensor_xy, tensor_yy
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // orientation, coherence
	output logic        m_tlast
);
	import sto_pkg::*;

	`include "structure_tensor_orientation_defines.svh"

	logic [15:0] eps_q;
	logic        en;
	sto_in_t     din;
	sto_stage_t  dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
		end else if (cfg_wen) begin
			eps_q <= cfg_wdata;
		end
	end

	assign en = !dout.vld || m_tready;
	assign s_tready = en;

	always_comb begin
		din.vld = s_tvalid;
		din.eof = s_tlast;
		din.xx  = s_tdata[31:0];
		din.xy  = s_tdata[63:32];
		din.yy  = s_tdata[95:64];
		din.eps = eps_q;
	end

	sto_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (din),
		.dout   (dout)
	);

	assign m_tvalid = dout.vld;
	assign m_tdata  = {dout.coh, dout.ori};
	assign m_tlast  = dout.eof;

	`STO_ASSERT_IMPL(a_coh_range, m_tvalid, m_tdata[31:16] <= COH_ONE)
	`STO_ASSERT_IMPL(a_ori_range, m_tvalid,
		($signed(m_tdata[15:0]) <= 16'sd25736) && ($signed(m_tdata[15:0]) >= -16'sd25736))
	`STO_ASSERT_ALWAYS(a_ready_stall, !(m_tvalid && !m_tready && s_tready))

endmodule
